// ===== design/cssc_pkg.sv =====
// Shared types and constants for the color sensor sequencer and classifier.
`default_nettype none

package cssc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_COUNT_BITS     = 16;
    localparam int DEF_GAIN_FRAC_BITS = 16;

    // Fixed field widths
    localparam int GAIN_BITS  = 24;
    localparam int LEVEL_BITS = 16;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    localparam logic [GAIN_BITS-1:0]  GAIN_ONE  = 24'd65536;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 16'hFFFF;
    localparam logic [LEVEL_BITS-1:0] LEVEL_CAP = 16'd255;
    localparam logic [LEVEL_BITS-1:0] BLUE_BIAS = 16'd3;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_GAIN_RED   = 2'd0;
    localparam logic [1:0] REG_GAIN_GREEN = 2'd1;
    localparam logic [1:0] REG_GAIN_BLUE  = 2'd2;

    // Input beat kinds
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_WINDOW  = 1'b1;

    // Filter select codes, s2*2+s3
    localparam logic [1:0] FILT_RED   = 2'd0;
    localparam logic [1:0] FILT_BLUE  = 2'd1;
    localparam logic [1:0] FILT_CLEAR = 2'd2;
    localparam logic [1:0] FILT_GREEN = 2'd3;

    typedef enum logic [3:0] {
        CLS_UNDEF  = 4'd0,
        CLS_WHITE  = 4'd1,
        CLS_BROWN  = 4'd2,
        CLS_BLACK  = 4'd3,
        CLS_RED    = 4'd4,
        CLS_YELLOW = 4'd5,
        CLS_ORANGE = 4'd6,
        CLS_PINK   = 4'd7,
        CLS_BLUE   = 4'd8,
        CLS_PURPLE = 4'd9,
        CLS_GREEN  = 4'd10,
        CLS_GRAY   = 4'd11
    } color_class_t;

endpackage

`default_nettype wire

// ===== design/color_sensor_sequencer_classifier_unit.sv =====
// Pipeline: an accepted item beat moves through three registers in order: counts,
//   products, result; the last one drives the result channel.
// Throughput: one item per cycle; the three gain multiplies run in parallel in
//   the product stage, so the whole pipe advances every cycle the output is free.
// Reset: rst_n clears phase, filter select, stored counts, pipe valids and sets
//   all three gains to 1.0 (65536); there is no clearing pass.
`default_nettype none

module color_sensor_sequencer_classifier_unit
    import cssc_pkg::*;
#(
    parameter int COUNT_BITS     = DEF_COUNT_BITS,
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // APB-style config port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_BITS-1:0]  paddr,
    input  wire logic [DATA_BITS-1:0]  pwdata,
    output logic      [DATA_BITS-1:0]  prdata,
    output logic                       pready,

    // item channel
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire logic                  kind,
    input  wire logic [COUNT_BITS-1:0] window_count,

    // result channel
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic      [1:0]            filter_code,
    output logic                       color_valid,
    output logic      [LEVEL_BITS-1:0] red_level,
    output logic      [LEVEL_BITS-1:0] green_level,
    output logic      [LEVEL_BITS-1:0] blue_level,
    output logic      [3:0]            color_class
);

    localparam int PROD_W = GAIN_BITS + COUNT_BITS;
    localparam int SH_W   = PROD_W - GAIN_FRAC_BITS;
    // wide enough for the shifted product plus the blue bias without wrapping
    localparam int EXT_W  = ((SH_W > LEVEL_BITS) ? SH_W : LEVEL_BITS) + 1;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_RED   = 3'd1,
        PH_GREEN = 3'd2,
        PH_BLUE  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    // ---------------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------------
    logic [GAIN_BITS-1:0] gain_red_reg, gain_green_reg, gain_blue_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_red_reg   <= GAIN_ONE;
            gain_green_reg <= GAIN_ONE;
            gain_blue_reg  <= GAIN_ONE;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_GAIN_RED:   gain_red_reg   <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_GREEN: gain_green_reg <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_BLUE:  gain_blue_reg  <= pwdata[GAIN_BITS-1:0];
                default: ;  // writes past the map are dropped
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_GAIN_RED:   prdata = DATA_BITS'(gain_red_reg);
            REG_GAIN_GREEN: prdata = DATA_BITS'(gain_green_reg);
            REG_GAIN_BLUE:  prdata = DATA_BITS'(gain_blue_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Pipe control: all stages move together whenever the output slot is
    // empty or being drained this cycle.
    // ---------------------------------------------------------------------
    logic advance;
    logic item_fire;
    logic result_valid_reg;

    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = advance;
    assign item_fire  = item_valid && advance;

    // ---------------------------------------------------------------------
    // Sequencer: phase walk red -> green -> blue -> clear
    // ---------------------------------------------------------------------
    phase_t                phase_reg, phase_next;
    logic [1:0]            filter_reg, filter_next;
    logic [COUNT_BITS-1:0] red_cnt_reg, red_cnt_next;
    logic [COUNT_BITS-1:0] green_cnt_reg, green_cnt_next;
    logic                  fire_next;

    always_comb
    begin
        phase_next     = phase_reg;
        filter_next    = filter_reg;
        red_cnt_next   = red_cnt_reg;
        green_cnt_next = green_cnt_reg;
        fire_next      = 1'b0;
        if (kind == KIND_RESTART)
        begin
            phase_next = PH_START;  // filter select left alone
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    filter_next = FILT_RED;
                    phase_next  = PH_RED;
                end
                PH_RED:
                begin
                    red_cnt_next = window_count;
                    filter_next  = FILT_GREEN;
                    phase_next   = PH_GREEN;
                end
                PH_GREEN:
                begin
                    green_cnt_next = window_count;
                    filter_next    = FILT_BLUE;
                    phase_next     = PH_BLUE;
                end
                PH_BLUE:
                begin
                    fire_next   = 1'b1;  // this window is blue: full set
                    filter_next = FILT_CLEAR;
                    phase_next  = PH_DONE;
                end
                default: ;  // past the set, window ends are ignored
            endcase
        end
    end

    // stage 1: counts latched with the beat
    logic                  s1_valid_reg;
    logic [1:0]            s1_filter_reg;
    logic                  s1_fire_reg;
    logic [COUNT_BITS-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            filter_reg    <= FILT_RED;
            red_cnt_reg   <= '0;
            green_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= item_valid;
            if (item_valid)
            begin
                phase_reg     <= phase_next;
                filter_reg    <= filter_next;
                red_cnt_reg   <= red_cnt_next;
                green_cnt_reg <= green_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_filter_reg <= filter_next;
            s1_fire_reg   <= fire_next;
            s1_red_reg    <= red_cnt_reg;
            s1_green_reg  <= green_cnt_reg;
            s1_blue_reg   <= window_count;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: white-balance products, one multiplier per channel
    // ---------------------------------------------------------------------
    logic              s2_valid_reg;
    logic [1:0]        s2_filter_reg;
    logic              s2_fire_reg;
    logic [PROD_W-1:0] s2_red_prod_reg, s2_green_prod_reg, s2_blue_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_filter_reg     <= s1_filter_reg;
            s2_fire_reg       <= s1_fire_reg;
            s2_red_prod_reg   <= PROD_W'(gain_red_reg)   * PROD_W'(s1_red_reg);
            s2_green_prod_reg <= PROD_W'(gain_green_reg) * PROD_W'(s1_green_reg);
            s2_blue_prod_reg  <= PROD_W'(gain_blue_reg)  * PROD_W'(s1_blue_reg);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: truncate, bias, saturate, bright clamp, classify
    // ---------------------------------------------------------------------
    logic [EXT_W-1:0]      red_ext, green_ext, blue_ext;
    logic [LEVEL_BITS-1:0] red_sat, green_sat, blue_sat;
    logic                  all_bright;
    logic [LEVEL_BITS-1:0] red_bal, green_bal, blue_bal;
    color_class_t          class_comb;

    assign red_ext   = EXT_W'(s2_red_prod_reg >> GAIN_FRAC_BITS);
    assign green_ext = EXT_W'(s2_green_prod_reg >> GAIN_FRAC_BITS);
    assign blue_ext  = EXT_W'(s2_blue_prod_reg >> GAIN_FRAC_BITS) + EXT_W'(BLUE_BIAS);

    assign red_sat   = (red_ext   > EXT_W'(LEVEL_MAX)) ? LEVEL_MAX : red_ext[LEVEL_BITS-1:0];
    assign green_sat = (green_ext > EXT_W'(LEVEL_MAX)) ? LEVEL_MAX : green_ext[LEVEL_BITS-1:0];
    assign blue_sat  = (blue_ext  > EXT_W'(LEVEL_MAX)) ? LEVEL_MAX : blue_ext[LEVEL_BITS-1:0];

    // all three over full scale: pin the set to plain white
    assign all_bright = (red_sat > LEVEL_CAP) && (green_sat > LEVEL_CAP)
                        && (blue_sat > LEVEL_CAP);
    assign red_bal    = all_bright ? LEVEL_CAP : red_sat;
    assign green_bal  = all_bright ? LEVEL_CAP : green_sat;
    assign blue_bal   = all_bright ? LEVEL_CAP : blue_sat;

    cssc_classify u_classify (
        .red         (red_bal),
        .green       (green_bal),
        .blue        (blue_bal),
        .color_class (class_comb)
    );

    logic [1:0]            filter_code_reg;
    logic                  color_valid_reg;
    logic [LEVEL_BITS-1:0] red_level_reg, green_level_reg, blue_level_reg;
    color_class_t          color_class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= s2_valid_reg;
    end

    // levels and class read as zero on beats that close no set
    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            filter_code_reg <= s2_filter_reg;
            color_valid_reg <= s2_fire_reg;
            red_level_reg   <= s2_fire_reg ? red_bal   : '0;
            green_level_reg <= s2_fire_reg ? green_bal : '0;
            blue_level_reg  <= s2_fire_reg ? blue_bal  : '0;
            color_class_reg <= s2_fire_reg ? class_comb : CLS_UNDEF;
        end
    end

    assign result_valid = result_valid_reg;
    assign filter_code  = filter_code_reg;
    assign color_valid  = color_valid_reg;
    assign red_level    = red_level_reg;
    assign green_level  = green_level_reg;
    assign blue_level   = blue_level_reg;
    assign color_class  = color_class_reg;

endmodule

`default_nettype wire

// ===== design/cssc_classify.sv =====
// Ordered threshold tree that maps a balanced RGB triple to a color class.
`default_nettype none

module cssc_classify
    import cssc_pkg::*;
(
    input  wire logic [LEVEL_BITS-1:0] red,
    input  wire logic [LEVEL_BITS-1:0] green,
    input  wire logic [LEVEL_BITS-1:0] blue,
    output color_class_t               color_class
);

    localparam logic [LEVEL_BITS-1:0] T_DIM    = 16'd12;
    localparam logic [LEVEL_BITS-1:0] T_DARK   = 16'd40;
    localparam logic [LEVEL_BITS-1:0] T_MID    = 16'd50;
    localparam logic [LEVEL_BITS-1:0] T_LOW    = 16'd100;
    localparam logic [LEVEL_BITS-1:0] T_HIGH   = 16'd120;
    localparam logic [LEVEL_BITS-1:0] T_BRIGHT = 16'd180;

    localparam logic signed [LEVEL_BITS:0] D_M3  = -17'sd3;
    localparam logic signed [LEVEL_BITS:0] D_1   = 17'sd1;
    localparam logic signed [LEVEL_BITS:0] D_2   = 17'sd2;
    localparam logic signed [LEVEL_BITS:0] D_4   = 17'sd4;
    localparam logic signed [LEVEL_BITS:0] D_10  = 17'sd10;
    localparam logic signed [LEVEL_BITS:0] D_20  = 17'sd20;
    localparam logic signed [LEVEL_BITS:0] D_40  = 17'sd40;
    localparam logic signed [LEVEL_BITS:0] D_50  = 17'sd50;
    localparam logic signed [LEVEL_BITS:0] D_60  = 17'sd60;

    logic signed [LEVEL_BITS:0] rg, rb, gb, bg, br, gr;
    logic                       gb_far2, gb_near20;

    assign rg = $signed({1'b0, red})   - $signed({1'b0, green});
    assign rb = $signed({1'b0, red})   - $signed({1'b0, blue});
    assign gb = $signed({1'b0, green}) - $signed({1'b0, blue});
    assign gr = -rg;
    assign br = -rb;
    assign bg = -gb;

    // |g-b| >= 2 and |g-b| < 20
    assign gb_far2   = (gb >= D_2) || (gb <= -D_2);
    assign gb_near20 = (gb < D_20) && (gb > -D_20);

    always_comb
    begin
        if (red < T_DIM && green < T_DIM && blue < T_DIM)
            color_class = CLS_UNDEF;
        else if (red > T_BRIGHT && green > T_BRIGHT && blue > T_BRIGHT && rg < D_40)
            color_class = CLS_WHITE;
        else if (red > green && gb_far2 && rg > D_10 && rg < D_40)
            color_class = CLS_BROWN;
        else if (red < T_DARK && green < T_DARK && blue < T_DARK)
            color_class = CLS_BLACK;
        else if (rg >= D_50 && rb >= D_50 && green < T_LOW && blue < T_LOW)
            color_class = CLS_RED;
        else if (red > green && green > blue && rg < D_60 && blue < T_BRIGHT
                 && red > T_HIGH && rg > D_10)
            color_class = CLS_YELLOW;
        else if (red > green && gb_near20 && rg > D_60 && blue < T_BRIGHT)
            color_class = CLS_ORANGE;
        else if (red > green && blue > green && red > blue && rg > D_50)
            color_class = CLS_PINK;
        else if (bg >= D_4 && br >= D_4)
            color_class = CLS_BLUE;
        else if (bg >= D_1 && br >= D_M3)
            color_class = CLS_PURPLE;
        else if (gr >= D_1 && gb >= D_10)
            color_class = CLS_GREEN;
        else if (red >= T_MID && red < T_BRIGHT && green >= T_MID && green < T_BRIGHT
                 && blue >= T_MID && blue < T_BRIGHT)
            color_class = CLS_GRAY;
        else
            color_class = CLS_UNDEF;
    end

endmodule

`default_nettype wire

// ===== design/cssc_checker.sv =====
// Port-level checks for the color sensor sequencer and classifier, bound to the top.
`default_nettype none

module cssc_checker
    import cssc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire logic [1:0]            filter_code,
    input wire logic                  color_valid,
    input wire logic [LEVEL_BITS-1:0] red_level,
    input wire logic [LEVEL_BITS-1:0] green_level,
    input wire logic [LEVEL_BITS-1:0] blue_level,
    input wire logic [3:0]            color_class
);

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable(filter_code) && $stable(color_valid) && $stable(color_class)
            && $stable(red_level) && $stable(green_level) && $stable(blue_level))
        else $error("result beat changed while stalled");

    // beats without a full set carry zero levels and no class
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !color_valid |-> red_level == '0 && green_level == '0
            && blue_level == '0 && color_class == 4'(CLS_UNDEF))
        else $error("levels nonzero on a beat without a color set");

    // bright clamp: never all three above full scale
    a_bright_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && color_valid |-> !(red_level > LEVEL_CAP
            && green_level > LEVEL_CAP && blue_level > LEVEL_CAP))
        else $error("bright clamp missed");

    // a completed set always switches to the clear filter and carries the blue bias
    a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && color_valid |-> filter_code == FILT_CLEAR && blue_level >= BLUE_BIAS)
        else $error("color set without clear filter or blue bias");

endmodule

bind color_sensor_sequencer_classifier_unit cssc_checker u_cssc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .filter_code  (filter_code),
    .color_valid  (color_valid),
    .red_level    (red_level),
    .green_level  (green_level),
    .blue_level   (blue_level),
    .color_class  (color_class)
);

`default_nettype wire

// ===== bench/color_sensor_sequencer_classifier_unit_test.sv =====
// Self-checking testbench for the color sensor sequencer and classifier unit.

module color_sensor_sequencer_classifier_unit_test;
    import cssc_pkg::*;

    localparam int         COUNT_W     = DEF_COUNT_BITS;
    localparam int         FRAC_W      = DEF_GAIN_FRAC_BITS;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_SLACK = 8;        // pipe is 3 deep, leave margin
    localparam int         REPORT_MAX  = 10;
    localparam logic [1:0] REG_SPARE   = 2'd3;     // unmapped slot, writes must be dropped

    // Where the sequencer stands between window beats.
    typedef enum logic [2:0] {
        WAIT_START,
        WAIT_RED,
        WAIT_GREEN,
        WAIT_BLUE,
        SET_DONE
    } window_phase_t;

    // One expected result beat.
    typedef struct packed {
        logic [1:0]            filter;
        logic                  valid;
        logic [LEVEL_BITS-1:0] red;
        logic [LEVEL_BITS-1:0] green;
        logic [LEVEL_BITS-1:0] blue;
        color_class_t          cls;
    } color_result_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [ADDR_BITS-1:0]  paddr        = '0;
    logic [DATA_BITS-1:0]  pwdata       = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    logic                  kind         = 1'b0;
    logic [COUNT_W-1:0]    window_count = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [1:0]            filter_code;
    logic                  color_valid;
    logic [LEVEL_BITS-1:0] red_level;
    logic [LEVEL_BITS-1:0] green_level;
    logic [LEVEL_BITS-1:0] blue_level;
    logic [3:0]            color_class;

    color_sensor_sequencer_classifier_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .window_count (window_count),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .filter_code  (filter_code),
        .color_valid  (color_valid),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level),
        .color_class  (color_class)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of gains, phase and held counts
    // ------------------------------------------------------------------
    logic [GAIN_BITS-1:0]  gain_q [3];
    window_phase_t         seq_phase;
    logic [COUNT_W-1:0]    held_red;
    logic [COUNT_W-1:0]    held_green;
    logic [1:0]            filter_sel;

    color_result_t         expected_colors [$];

    // Run bookkeeping
    int          cycle_count     = 0;
    int          failure_count   = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int          color_sets      = 0;
    int          gain_settings   = 0;
    logic [11:0] class_seen      = '0;
    int          idle_pct        = 0;   // sender gap odds, percent per cycle
    int          stall_pct       = 0;   // receiver stall odds, percent per cycle

    // ------------------------------------------------------------------
    // Clock, reset, cycle count
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reset is held once, at the start.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d result beats still pending",
                 cycle_count, expected_colors.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Q8.16 gain times count, truncated, plus bias, saturated to 16 bits.
    function automatic logic [LEVEL_BITS-1:0] gain_level(logic [GAIN_BITS-1:0] gain,
                                                         logic [COUNT_W-1:0] count,
                                                         logic [LEVEL_BITS-1:0] bias);
        logic [63:0] prod;
        prod = (64'(gain) * 64'(count)) >> FRAC_W;
        prod = prod + 64'(bias);
        return (prod > 64'(LEVEL_MAX)) ? LEVEL_MAX : prod[LEVEL_BITS-1:0];
    endfunction

    function automatic int spread(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Threshold tree; order matters, first hit wins.
    function automatic color_class_t classify_levels(int r, int g, int b);
        if (r < 12 && g < 12 && b < 12)
            return CLS_UNDEF;
        if (r > 180 && g > 180 && b > 180 && (r - g) < 40)
            return CLS_WHITE;
        if (r > g && spread(g, b) >= 2 && (r - g) > 10 && (r - g) < 40)
            return CLS_BROWN;
        if (r < 40 && g < 40 && b < 40)
            return CLS_BLACK;
        if ((r - g) >= 50 && (r - b) >= 50 && g < 100 && b < 100)
            return CLS_RED;
        if (r > g && g > b && (r - g) < 60 && b < 180 && r > 120 && (r - g) > 10)
            return CLS_YELLOW;
        if (r > g && spread(g, b) < 20 && (r - g) > 60 && b < 180)
            return CLS_ORANGE;
        if (r > g && b > g && r > b && (r - g) > 50)
            return CLS_PINK;
        if ((b - g) >= 4 && (b - r) >= 4)
            return CLS_BLUE;
        if ((b - g) >= 1 && (b - r) >= -3)
            return CLS_PURPLE;
        if ((g - r) >= 1 && (g - b) >= 10)
            return CLS_GREEN;
        if (r >= 50 && r < 180 && g >= 50 && g < 180 && b >= 50 && b < 180)
            return CLS_GRAY;
        return CLS_UNDEF;
    endfunction

    // Advance the predictor by one accepted item beat and return its result.
    function automatic color_result_t step_sequencer(logic item_kind,
                                                     logic [COUNT_W-1:0] count);
        color_result_t         res;
        logic [LEVEL_BITS-1:0] r;
        logic [LEVEL_BITS-1:0] g;
        logic [LEVEL_BITS-1:0] b;
        res.valid = 1'b0;
        res.red   = '0;
        res.green = '0;
        res.blue  = '0;
        res.cls   = CLS_UNDEF;
        if (item_kind == KIND_RESTART)
        begin
            // restart keeps the filter select as it is
            seq_phase = WAIT_START;
        end
        else
        begin
            case (seq_phase)
                WAIT_START:
                begin
                    filter_sel = FILT_RED;
                    seq_phase  = WAIT_RED;
                end
                WAIT_RED:
                begin
                    held_red   = count;
                    filter_sel = FILT_GREEN;
                    seq_phase  = WAIT_GREEN;
                end
                WAIT_GREEN:
                begin
                    held_green = count;
                    filter_sel = FILT_BLUE;
                    seq_phase  = WAIT_BLUE;
                end
                WAIT_BLUE:
                begin
                    r = gain_level(gain_q[REG_GAIN_RED], held_red, '0);
                    g = gain_level(gain_q[REG_GAIN_GREEN], held_green, '0);
                    b = gain_level(gain_q[REG_GAIN_BLUE], count, BLUE_BIAS);
                    // bright on all three channels: clamp the triple to 255
                    if (r > LEVEL_CAP && g > LEVEL_CAP && b > LEVEL_CAP)
                    begin
                        r = LEVEL_CAP;
                        g = LEVEL_CAP;
                        b = LEVEL_CAP;
                    end
                    res.valid  = 1'b1;
                    res.red    = r;
                    res.green  = g;
                    res.blue   = b;
                    res.cls    = classify_levels(int'(r), int'(g), int'(b));
                    filter_sel = FILT_CLEAR;
                    seq_phase  = SET_DONE;
                end
                default:
                begin
                    // window after a finished set: nothing moves
                end
            endcase
        end
        res.filter = filter_sel;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Failure reporting: first few in full, the rest only counted
    // ------------------------------------------------------------------
    task automatic report_failure(string msg);
        failure_count++;
        if (failure_count <= REPORT_MAX)
            $display("[cycle %0d] MISMATCH %s", cycle_count, msg);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            report_failure($sformatf("%s on result %0d: expected 0x%0h, got 0x%0h",
                                     name, results_checked, want, got));
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and the beat checker
    // ------------------------------------------------------------------
    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= stall_pct);

    // Every accepted result beat is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_result_beat
        color_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_colors.size() == 0)
            begin
                report_failure("result beat with no item beat pending");
            end
            else
            begin
                want = expected_colors.pop_front();
                results_checked++;
                check_field("filter_code", 16'(want.filter), 16'(filter_code));
                check_field("color_valid", 16'(want.valid), 16'(color_valid));
                check_field("red_level", want.red, red_level);
                check_field("green_level", want.green, green_level);
                check_field("blue_level", want.blue, blue_level);
                check_field("color_class", 16'(want.cls), 16'(color_class));
                if (want.valid)
                begin
                    color_sets++;
                    class_seen[want.cls] = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------

    // Send one item beat. Valid stays up between back-to-back beats; a gap
    // drops it and puts junk on the payload meanwhile.
    task automatic send_item(logic item_kind, logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid   <= 1'b0;
            kind         <= 1'($urandom_range(1));
            window_count <= COUNT_W'($urandom);
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= item_kind;
        window_count <= count;
        do @(posedge clk); while (item_ready !== 1'b1);
        expected_colors.push_back(step_sequencer(item_kind, count));
        items_sent++;
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic close_stream_and_drain();
        item_valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Register access; only ever used while the pipe is empty
    // ------------------------------------------------------------------
    task automatic apb_write(logic [1:0] reg_idx, logic [DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // upper byte is dropped, the spare slot holds nothing
        if (reg_idx != REG_SPARE)
            gain_q[reg_idx] = data[GAIN_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic apb_read(logic [1:0] reg_idx, output logic [DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_gain_readback();
        logic [1:0]           reg_idx;
        logic [DATA_BITS-1:0] rd;
        for (reg_idx = REG_GAIN_RED; reg_idx <= REG_GAIN_BLUE; reg_idx++)
        begin
            apb_read(reg_idx, rd);
            if (rd !== DATA_BITS'(gain_q[reg_idx]))
                report_failure($sformatf("gain register %0d readback: expected 0x%0h, got 0x%0h",
                                         reg_idx, gain_q[reg_idx], rd));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Level triples that land in each class at unity gain.
    function automatic logic [47:0] seed_levels(color_class_t c);
        case (c)
            CLS_WHITE:  return {16'd200, 16'd190, 16'd200};
            CLS_BROWN:  return {16'd100, 16'd80,  16'd60};
            CLS_BLACK:  return {16'd20,  16'd20,  16'd20};
            CLS_RED:    return {16'd200, 16'd50,  16'd50};
            CLS_YELLOW: return {16'd200, 16'd150, 16'd100};
            CLS_ORANGE: return {16'd250, 16'd150, 16'd140};
            CLS_PINK:   return {16'd250, 16'd100, 16'd200};
            CLS_BLUE:   return {16'd50,  16'd60,  16'd120};
            CLS_PURPLE: return {16'd100, 16'd90,  16'd98};
            CLS_GREEN:  return {16'd50,  16'd150, 16'd60};
            CLS_GRAY:   return {16'd100, 16'd100, 16'd100};
            default:    return {16'd5,   16'd5,   16'd8};
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] level_to_count(int lvl);
        return (lvl < 0) ? '0 : COUNT_W'(lvl);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All three gains read back as 1.0 out of reset.
    task automatic test_register_defaults();
        check_gain_readback();
    endtask

    // Hand-picked windows at unity gain, no idling.
    task automatic test_directed_windows();
        idle_pct  = 0;
        stall_pct = 0;
        // full set at max counts: blue saturates, all three clamp to 255
        send_item(KIND_WINDOW, 16'hFFFF);    // red select, count ignored
        send_item(KIND_WINDOW, 16'hFFFF);
        send_item(KIND_WINDOW, 16'hFFFF);
        send_item(KIND_WINDOW, 16'hFFFF);
        // window after the set changes nothing
        send_item(KIND_WINDOW, 16'h1234);
        // restart leaves the clear filter applied
        send_item(KIND_RESTART, 16'hFFFF);
        send_item(KIND_WINDOW, 16'h0000);
        send_item(KIND_WINDOW, 16'h0000);
        // restart mid-set, green filter stays
        send_item(KIND_RESTART, 16'h0000);
        // all-zero set: only the blue bias shows
        send_item(KIND_WINDOW, 16'h0000);
        send_item(KIND_WINDOW, 16'h0000);
        send_item(KIND_WINDOW, 16'h0000);
        send_item(KIND_WINDOW, 16'h0000);
        // back-to-back restarts
        send_item(KIND_RESTART, 16'h5555);
        send_item(KIND_RESTART, 16'hAAAA);
        // blue lands exactly on 65535 with the bias; green stays low, no clamp
        send_item(KIND_WINDOW, 16'hAAAA);
        send_item(KIND_WINDOW, 16'd300);
        send_item(KIND_WINDOW, 16'd10);
        send_item(KIND_WINDOW, 16'd65532);
        // just over 255 on all three: clamp edge
        send_item(KIND_RESTART, 16'h0000);
        send_item(KIND_WINDOW, 16'h5555);
        send_item(KIND_WINDOW, 16'd256);
        send_item(KIND_WINDOW, 16'd256);
        send_item(KIND_WINDOW, 16'd253);
        close_stream_and_drain();
    endtask

    // Upper data bits are masked, the spare slot is ignored.
    task automatic test_register_writes();
        apb_write(REG_GAIN_RED,   32'hFF12_3456);
        apb_write(REG_GAIN_GREEN, 32'h80FE_DCBA);
        apb_write(REG_GAIN_BLUE,  32'h0100_0001);
        apb_write(REG_SPARE,      32'hFFFF_FFFF);
        check_gain_readback();
    endtask

    // Load gains, then mostly well-formed sets with mixed content, plus
    // broken sets and stray beats.
    task automatic test_random_traffic(logic [DATA_BITS-1:0] red_gain,
                                       logic [DATA_BITS-1:0] green_gain,
                                       logic [DATA_BITS-1:0] blue_gain,
                                       int idle_p, int stall_p, int n_items);
        int                 stop_at;
        int                 pick;
        int                 mode;
        int                 jit;
        logic [47:0]        seed;
        logic [COUNT_W-1:0] red_c;
        logic [COUNT_W-1:0] green_c;
        logic [COUNT_W-1:0] blue_c;
        apb_write(REG_GAIN_RED,   red_gain);
        apb_write(REG_GAIN_GREEN, green_gain);
        apb_write(REG_GAIN_BLUE,  blue_gain);
        gain_settings++;
        idle_pct  = idle_p;
        stall_pct = stall_p;
        stop_at   = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                mode = $urandom_range(99);
                if (mode < 40)
                begin
                    // near a class seed, sometimes exact
                    seed    = seed_levels(color_class_t'($urandom_range(11)));
                    jit     = $urandom_range(1) ? 4 : 0;
                    red_c   = level_to_count(int'(seed[47:32])
                                             + int'($urandom_range(2 * jit)) - jit);
                    green_c = level_to_count(int'(seed[31:16])
                                             + int'($urandom_range(2 * jit)) - jit);
                    blue_c  = level_to_count(int'(seed[15:0]) - 3
                                             + int'($urandom_range(2 * jit)) - jit);
                end
                else if (mode < 75)
                begin
                    // small counts, around the tree thresholds
                    red_c   = COUNT_W'($urandom_range(300));
                    green_c = COUNT_W'($urandom_range(300));
                    blue_c  = COUNT_W'($urandom_range(300));
                end
                else
                begin
                    red_c   = COUNT_W'($urandom);
                    green_c = COUNT_W'($urandom);
                    blue_c  = COUNT_W'($urandom);
                end
                // now and then skip the restart: windows may then hit a done set
                if (pick < 68)
                    send_item(KIND_RESTART, COUNT_W'($urandom));
                send_item(KIND_WINDOW, COUNT_W'($urandom));
                send_item(KIND_WINDOW, red_c);
                send_item(KIND_WINDOW, green_c);
                send_item(KIND_WINDOW, blue_c);
            end
            else if (pick < 88)
            begin
                // set cut short; the next one may or may not restart
                send_item(KIND_RESTART, COUNT_W'($urandom));
                send_item(KIND_WINDOW, COUNT_W'($urandom));
                repeat ($urandom_range(2))
                    send_item(KIND_WINDOW, COUNT_W'($urandom));
            end
            else
            begin
                send_item(1'($urandom_range(1)), COUNT_W'($urandom));
            end
        end
        close_stream_and_drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        gain_q[REG_GAIN_RED]   = GAIN_ONE;
        gain_q[REG_GAIN_GREEN] = GAIN_ONE;
        gain_q[REG_GAIN_BLUE]  = GAIN_ONE;
        seq_phase  = WAIT_START;
        held_red   = '0;
        held_green = '0;
        filter_sel = FILT_RED;

        wait (rst_n === 1'b1);
        @(posedge clk);

        test_register_defaults();
        test_directed_windows();
        test_register_writes();
        // unity gains, free-running both sides
        test_random_traffic(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 400);
        // gains between 0.5 and 2.0, sparse sender
        test_random_traffic(32'($urandom_range(32'h2_0000, 32'h8000)),
                            32'($urandom_range(32'h2_0000, 32'h8000)),
                            32'($urandom_range(32'h2_0000, 32'h8000)), 77, 0, 350);
        // max gains with junk in the upper byte, slow receiver
        test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 77, 300);
        // zero gains: levels collapse, blue keeps its bias
        test_random_traffic(32'h0, 32'h0, 32'h0, 19, 19, 250);
        // anything goes
        test_random_traffic($urandom, $urandom, $urandom, 0, 0, 300);
        // unbalanced gains around unity
        test_random_traffic(32'h0001_0000, 32'h0000_8000, 32'h0001_FFFF, 19, 19, 300);

        $display("Sent %0d item beats, checked %0d result beats with %0d color sets",
                 items_sent, results_checked, color_sets);
        $display("Reached %0d of 12 color classes over %0d gain settings under traffic",
                 $countones(class_seen), gain_settings);
        if (failure_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches in total", failure_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== color_sensor_sequencer_classifier_unit.f =====
design/cssc_pkg.sv
design/cssc_classify.sv
design/color_sensor_sequencer_classifier_unit.sv
design/cssc_checker.sv
bench/color_sensor_sequencer_classifier_unit_test.sv
